// ===== sv/ihds_pkg.sv =====
// package for the image header dimension sniffer
// file kind codes, magic bytes, marker bytes and field offsets; no dependencies
package ihds_pkg;

  typedef enum logic [2:0] {
    KindUnknown = 3'd0,
    KindJpeg    = 3'd1,
    KindBmp     = 3'd2,
    KindPng     = 3'd3,
    KindGif     = 3'd4
  } kind_e;

  localparam int unsigned WinDepth = 12;
  localparam logic [3:0]  PosMax   = 4'd15;

  // first bytes of each kind
  localparam logic [7:0] JpegMagic0 = 8'hFF;
  localparam logic [7:0] JpegMagic1 = 8'hD8;
  localparam logic [7:0] JpegMagic2 = 8'hFF;
  localparam logic [7:0] BmpMagic0  = 8'h42;
  localparam logic [7:0] BmpMagic1  = 8'h4D;
  localparam logic [7:0] GifMagic0  = 8'h47;
  localparam logic [7:0] GifMagic1  = 8'h49;
  localparam logic [7:0] GifMagic2  = 8'h46;
  localparam logic [7:0] GifMagic3  = 8'h38;
  localparam logic [7:0] PngMagic0  = 8'h89;
  localparam logic [7:0] PngMagic1  = 8'h50;
  localparam logic [7:0] PngMagic2  = 8'h4E;
  localparam logic [7:0] PngMagic3  = 8'h47;

  // two-byte dimension markers
  localparam logic [7:0] JpegMark0 = 8'hFF;
  localparam logic [7:0] JpegMark1 = 8'hC0;
  localparam logic [7:0] BmpMark0  = 8'h28;
  localparam logic [7:0] BmpMark1  = 8'h00;
  localparam logic [7:0] PngMark0  = 8'h49;
  localparam logic [7:0] PngMark1  = 8'h48;
  localparam logic [7:0] GifMark0  = 8'h00;
  localparam logic [7:0] GifMark1  = 8'h2C;

  // smallest byte index at which the last field byte can arrive
  localparam logic [3:0] JpegMinPos = 4'd8;
  localparam logic [3:0] BmpMinPos  = 4'd11;
  localparam logic [3:0] PngMinPos  = 4'd11;
  localparam logic [3:0] GifMinPos  = 4'd9;

endpackage

// ===== sv/image_header_dimension_sniffer_core.sv =====
// image header dimension sniffer, top level
// uses ihds_pkg for kind codes and magic and marker bytes
// Takes one file byte per beat and accepts a new beat in every cycle: a byte
// is classified and scanned combinationally between the input beat and the
// result register, against a twelve-byte window of the newest bytes. The
// result beat (kind, found flag, width, height) is registered in the cycle after
// the beat flagged end_of_file, and the next byte starts a new file. Input is
// held off only while a result waits to be taken and the output side stalls.
module image_header_dimension_sniffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  file_kind_o,
  output logic        size_found_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o
);

  localparam int unsigned HistDepth = ihds_pkg::WinDepth - 1;

  logic [3:0]      pos_q, pos_d;
  ihds_pkg::kind_e kind_q, kind_d;
  logic            found_q, found_d;
  logic [31:0]     width_q, width_d;
  logic [31:0]     height_q, height_d;
  logic [7:0]      hist_q [HistDepth];
  logic [7:0]      win [ihds_pkg::WinDepth];

  logic            out_valid_q;
  ihds_pkg::kind_e out_kind_q;
  logic            out_found_q;
  logic [31:0]     out_width_q, out_height_q;

  logic            accept;
  logic [7:0]      b0, b1, b2, b3;
  logic [3:1]      pres;
  ihds_pkg::kind_e class_kind;
  logic            hit;
  logic [31:0]     cap_w, cap_h;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    win[0] = data_byte_i;
    for (int k = 1; k < ihds_pkg::WinDepth; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  // file bytes 0..3 as seen from the current index
  always_comb begin
    b0 = win[0];
    b1 = 8'h00;
    b2 = 8'h00;
    b3 = 8'h00;
    case (pos_q[1:0])
      2'd0: begin
        pres = 3'b000;
      end
      2'd1: begin
        b0 = win[1]; b1 = win[0];
        pres = 3'b001;
      end
      2'd2: begin
        b0 = win[2]; b1 = win[1]; b2 = win[0];
        pres = 3'b011;
      end
      default: begin
        b0 = win[3]; b1 = win[2]; b2 = win[1]; b3 = win[0];
        pres = 3'b111;
      end
    endcase
  end

  always_comb begin
    if (pres[2] && b0 == ihds_pkg::JpegMagic0 && b1 == ihds_pkg::JpegMagic1 &&
        b2 == ihds_pkg::JpegMagic2) begin
      class_kind = ihds_pkg::KindJpeg;
    end else if (pres[1] && b0 == ihds_pkg::BmpMagic0 && b1 == ihds_pkg::BmpMagic1) begin
      class_kind = ihds_pkg::KindBmp;
    end else if (pres[3] && b0 == ihds_pkg::GifMagic0 && b1 == ihds_pkg::GifMagic1 &&
                 b2 == ihds_pkg::GifMagic2 && b3 == ihds_pkg::GifMagic3) begin
      class_kind = ihds_pkg::KindGif;
    end else if (pres[3] && b0 == ihds_pkg::PngMagic0 && b1 == ihds_pkg::PngMagic1 &&
                 b2 == ihds_pkg::PngMagic2 && b3 == ihds_pkg::PngMagic3) begin
      class_kind = ihds_pkg::KindPng;
    end else begin
      class_kind = ihds_pkg::KindUnknown;
    end
  end

  always_comb begin
    kind_d = kind_q;
    if (pos_q == 4'd3 || (end_of_file_i && pos_q < 4'd3)) begin
      kind_d = class_kind;
    end
  end

  // marker search on the window
  always_comb begin
    hit   = 1'b0;
    cap_w = '0;
    cap_h = '0;
    case (kind_d)
      ihds_pkg::KindJpeg: begin
        hit   = pos_q >= ihds_pkg::JpegMinPos && win[8] == ihds_pkg::JpegMark0 &&
                win[7] == ihds_pkg::JpegMark1;
        cap_w = {16'h0000, win[1], win[0]};
        cap_h = {16'h0000, win[3], win[2]};
      end
      ihds_pkg::KindBmp: begin
        hit   = pos_q >= ihds_pkg::BmpMinPos && win[11] == ihds_pkg::BmpMark0 &&
                win[10] == ihds_pkg::BmpMark1;
        cap_w = {win[4], win[5], win[6], win[7]};
        cap_h = {win[0], win[1], win[2], win[3]};
      end
      ihds_pkg::KindPng: begin
        hit   = pos_q >= ihds_pkg::PngMinPos && win[11] == ihds_pkg::PngMark0 &&
                win[10] == ihds_pkg::PngMark1;
        cap_w = {win[7], win[6], win[5], win[4]};
        cap_h = {win[3], win[2], win[1], win[0]};
      end
      ihds_pkg::KindGif: begin
        hit   = pos_q >= ihds_pkg::GifMinPos && win[9] == ihds_pkg::GifMark0 &&
                win[8] == ihds_pkg::GifMark1;
        cap_w = {16'h0000, win[2], win[3]};
        cap_h = {16'h0000, win[0], win[1]};
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    found_d  = found_q;
    width_d  = width_q;
    height_d = height_q;
    if (!found_q && hit) begin
      found_d  = 1'b1;
      width_d  = cap_w;
      height_d = cap_h;
    end
    pos_d = (pos_q < ihds_pkg::PosMax) ? pos_q + 4'd1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      kind_q      <= ihds_pkg::KindUnknown;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (end_of_file_i) begin
          pos_q   <= '0;
          kind_q  <= ihds_pkg::KindUnknown;
          found_q <= 1'b0;
        end else begin
          pos_q   <= pos_d;
          kind_q  <= kind_d;
          found_q <= found_d;
        end
      end
      if (accept && end_of_file_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= win[k];
      end
      width_q  <= width_d;
      height_q <= height_d;
      if (end_of_file_i) begin
        out_kind_q   <= kind_d;
        out_found_q  <= found_d;
        out_width_q  <= found_d ? width_d : '0;
        out_height_q <= found_d ? height_d : '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign file_kind_o    = out_kind_q;
  assign size_found_o   = out_found_q;
  assign image_width_o  = out_width_q;
  assign image_height_o = out_height_q;

endmodule

// ===== sv/ihds_checker.sv =====
// port-level checks for the image header dimension sniffer
// uses ihds_pkg for kind codes; bound to image_header_dimension_sniffer_core
module ihds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        end_of_file_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  file_kind_o,
  input logic        size_found_o,
  input logic [31:0] image_width_o,
  input logic [31:0] image_height_o
);

  // no size means zero dimensions
  a_zero_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !size_found_o |-> image_width_o == '0 && image_height_o == '0)
    else $error("dimensions nonzero without a size");

  // unknown files never report a size
  a_unknown_nosize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_kind_o == ihds_pkg::KindUnknown |-> !size_found_o)
    else $error("size found for unknown file");

  // input is only held off by a pending result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

  // a byte that is not the last one gives no result beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !end_of_file_i && (!out_valid_o || out_ready_i)
      |=> !out_valid_o)
    else $error("result beat without end of file");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(file_kind_o) &&
      $stable(size_found_o) && $stable(image_width_o) && $stable(image_height_o))
    else $error("stalled result beat changed");

endmodule

bind image_header_dimension_sniffer_core ihds_checker u_ihds_checker (.*);

// ===== tb/sv/image_header_dimension_sniffer_core_tb.sv =====
// testbench for image_header_dimension_sniffer_core: files of bytes go in, one
// result beat per file comes out and is checked against a local model
// depends on ihds_pkg and the core; random stalls on both sides
module image_header_dimension_sniffer_core_tb;

  localparam int LongStall     = 300;
  localparam int WatchdogLimit = 3000;
  localparam int TailCycles    = 10;
  localparam int TargetBytes   = 950;

  typedef struct packed {
    ihds_pkg::kind_e kind;
    logic            found;
    logic [31:0]     width;
    logic [31:0]     height;
  } dims_t;

  class header_dims_tracker;
    logic [3:0]      pos;
    logic [7:0]      win [ihds_pkg::WinDepth];
    ihds_pkg::kind_e kind;
    logic            found;
    logic [31:0]     held_w;
    logic [31:0]     held_h;
    dims_t           pending_dims [$];
    int              errors;

    function new();
      clear_file();
      errors = 0;
    endfunction

    function void clear_file();
      pos = '0;
      foreach (win[k]) win[k] = '0;
      kind = ihds_pkg::KindUnknown;
      found = 1'b0;
      held_w = '0;
      held_h = '0;
    endfunction

    function int pending();
      return pending_dims.size();
    endfunction

    // byte j of the file, only if already present
    function logic magic_at(int unsigned p, int unsigned j, logic [7:0] v);
      return (j <= p) && (win[p - j] == v);
    endfunction

    function ihds_pkg::kind_e classify(int unsigned p);
      if (magic_at(p, 0, ihds_pkg::JpegMagic0) && magic_at(p, 1, ihds_pkg::JpegMagic1) &&
          magic_at(p, 2, ihds_pkg::JpegMagic2))
        return ihds_pkg::KindJpeg;
      if (magic_at(p, 0, ihds_pkg::BmpMagic0) && magic_at(p, 1, ihds_pkg::BmpMagic1))
        return ihds_pkg::KindBmp;
      if (magic_at(p, 0, ihds_pkg::GifMagic0) && magic_at(p, 1, ihds_pkg::GifMagic1) &&
          magic_at(p, 2, ihds_pkg::GifMagic2) && magic_at(p, 3, ihds_pkg::GifMagic3))
        return ihds_pkg::KindGif;
      if (magic_at(p, 0, ihds_pkg::PngMagic0) && magic_at(p, 1, ihds_pkg::PngMagic1) &&
          magic_at(p, 2, ihds_pkg::PngMagic2) && magic_at(p, 3, ihds_pkg::PngMagic3))
        return ihds_pkg::KindPng;
      return ihds_pkg::KindUnknown;
    endfunction

    function void capture(int unsigned p);
      if (found) return;
      case (kind)
        ihds_pkg::KindJpeg: begin
          if (p >= ihds_pkg::JpegMinPos && win[8] == ihds_pkg::JpegMark0 &&
              win[7] == ihds_pkg::JpegMark1) begin
            held_w = {16'h0000, win[1], win[0]};
            held_h = {16'h0000, win[3], win[2]};
            found = 1'b1;
          end
        end
        ihds_pkg::KindBmp: begin
          if (p >= ihds_pkg::BmpMinPos && win[11] == ihds_pkg::BmpMark0 &&
              win[10] == ihds_pkg::BmpMark1) begin
            held_w = {win[4], win[5], win[6], win[7]};
            held_h = {win[0], win[1], win[2], win[3]};
            found = 1'b1;
          end
        end
        ihds_pkg::KindPng: begin
          if (p >= ihds_pkg::PngMinPos && win[11] == ihds_pkg::PngMark0 &&
              win[10] == ihds_pkg::PngMark1) begin
            held_w = {win[7], win[6], win[5], win[4]};
            held_h = {win[3], win[2], win[1], win[0]};
            found = 1'b1;
          end
        end
        ihds_pkg::KindGif: begin
          if (p >= ihds_pkg::GifMinPos && win[9] == ihds_pkg::GifMark0 &&
              win[8] == ihds_pkg::GifMark1) begin
            held_w = {16'h0000, win[2], win[3]};
            held_h = {16'h0000, win[0], win[1]};
            found = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      int unsigned p;
      dims_t       r;
      p = pos;
      for (int k = ihds_pkg::WinDepth - 1; k > 0; k--) win[k] = win[k - 1];
      win[0] = b;
      if (p == 3 || (eof && p < 3)) kind = classify(p);
      capture(p);
      if (pos < ihds_pkg::PosMax) pos++;
      if (eof) begin
        r.kind = kind;
        r.found = found;
        r.width = found ? held_w : '0;
        r.height = found ? held_h : '0;
        pending_dims.push_back(r);
        clear_file();
      end
    endfunction

    function void check_result(logic [2:0] kind_o, logic found_o, logic [31:0] w,
                               logic [31:0] h);
      dims_t e;
      if (pending_dims.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: kind %0d found %0b width %h height %h",
                   kind_o, found_o, w, h);
        return;
      end
      e = pending_dims.pop_front();
      if (kind_o !== e.kind || found_o !== e.found || w !== e.width || h !== e.height) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected kind %0d found %0b width %h height %h, %s",
                   e.kind, e.found, e.width, e.height, "see next line");
        if (errors <= 10)
          $display("  actual kind %0d found %0b width %h height %h", kind_o, found_o, w, h);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  file_kind_o;
  logic        size_found_o;
  logic [31:0] image_width_o;
  logic [31:0] image_height_o;

  header_dims_tracker dims = new();

  int send_idle_pct = 29;
  int recv_idle_pct = 87;
  int stalls_asked  = 0;
  int stalls_served = 0;
  int bytes_offered = 0;
  int quiet_cycles  = 0;

  image_header_dimension_sniffer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .file_kind_o    (file_kind_o),
    .size_found_o   (size_found_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) dims.note_byte(data_byte_i, end_of_file_i);
      if (out_valid_o && out_ready_i)
        dims.check_result(file_kind_o, size_found_o, image_width_o, image_height_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("image_header_dimension_sniffer_core_tb: errors");
        $finish;
      end
    end
  end

  // result side, with a single long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stalls_served != stalls_asked) begin
        out_ready_i <= 1'b0;
        stalls_served++;
        repeat (LongStall) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] field_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_magic(ref logic [7:0] f[$], input ihds_pkg::kind_e k);
    case (k)
      ihds_pkg::KindJpeg: begin
        f.push_back(ihds_pkg::JpegMagic0);
        f.push_back(ihds_pkg::JpegMagic1);
        f.push_back(ihds_pkg::JpegMagic2);
      end
      ihds_pkg::KindBmp: begin
        f.push_back(ihds_pkg::BmpMagic0);
        f.push_back(ihds_pkg::BmpMagic1);
      end
      ihds_pkg::KindPng: begin
        f.push_back(ihds_pkg::PngMagic0);
        f.push_back(ihds_pkg::PngMagic1);
        f.push_back(ihds_pkg::PngMagic2);
        f.push_back(ihds_pkg::PngMagic3);
      end
      default: begin
        f.push_back(ihds_pkg::GifMagic0);
        f.push_back(ihds_pkg::GifMagic1);
        f.push_back(ihds_pkg::GifMagic2);
        f.push_back(ihds_pkg::GifMagic3);
      end
    endcase
  endfunction

  function automatic void add_marker(ref logic [7:0] f[$], input ihds_pkg::kind_e k,
                                     input bit cut);
    int n;
    case (k)
      ihds_pkg::KindJpeg: begin
        f.push_back(ihds_pkg::JpegMark0);
        f.push_back(ihds_pkg::JpegMark1);
        n = 7;
      end
      ihds_pkg::KindBmp: begin
        f.push_back(ihds_pkg::BmpMark0);
        f.push_back(ihds_pkg::BmpMark1);
        n = 10;
      end
      ihds_pkg::KindPng: begin
        f.push_back(ihds_pkg::PngMark0);
        f.push_back(ihds_pkg::PngMark1);
        n = 10;
      end
      default: begin
        f.push_back(ihds_pkg::GifMark0);
        f.push_back(ihds_pkg::GifMark1);
        n = 8;
      end
    endcase
    // fields running past the end of the file
    if (cut) n = $urandom_range(0, n - 1);
    repeat (n) f.push_back(field_byte());
  endfunction

  function automatic void make_file(ref logic [7:0] f[$]);
    int              pick;
    int              idx;
    bit              cut;
    ihds_pkg::kind_e k;
    f = {};
    pick = $urandom_range(0, 99);
    k = ihds_pkg::kind_e'(3'($urandom_range(1, 4)));
    if (pick < 75) begin
      cut = ($urandom_range(0, 9) == 0);
      add_magic(f, k);
      repeat ($urandom_range(0, 5)) f.push_back(field_byte());
      add_marker(f, k, cut);
      if (!cut) begin
        if ($urandom_range(0, 3) == 0) add_marker(f, k, 1'b0);
        repeat ($urandom_range(0, 3)) f.push_back(field_byte());
      end
    end else if (pick < 85) begin
      // broken magic
      add_magic(f, k);
      idx = $urandom_range(0, f.size() - 1);
      f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
      repeat ($urandom_range(0, 4)) f.push_back(field_byte());
      if ($urandom_range(0, 1) == 1) add_marker(f, k, 1'b0);
    end else if (pick < 93) begin
      // short file
      add_magic(f, k);
      f = f[0:$urandom_range(0, f.size() - 1)];
    end else begin
      repeat ($urandom_range(1, 20)) f.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    bytes_offered++;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_file(ref logic [7:0] f[$]);
    foreach (f[k]) send_byte(f[k], k == f.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (dims.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] f [$];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    end_of_file_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    f = {8'hFF};
    send_file(f);
    f = {ihds_pkg::BmpMagic0, ihds_pkg::BmpMagic1};
    send_file(f);
    f = {ihds_pkg::JpegMagic0, ihds_pkg::JpegMagic1, ihds_pkg::JpegMagic2};
    send_file(f);
    // marker overlaps the last magic byte
    f = {ihds_pkg::JpegMagic0, ihds_pkg::JpegMagic1, ihds_pkg::JpegMagic2,
         ihds_pkg::JpegMark1, 8'h00, 8'h08, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_file(f);
    f = {ihds_pkg::GifMagic0, ihds_pkg::GifMagic1, ihds_pkg::GifMagic2,
         ihds_pkg::GifMagic3};
    send_file(f);
    f = {ihds_pkg::PngMagic0, ihds_pkg::PngMagic1, ihds_pkg::PngMagic2,
         ihds_pkg::PngMagic3};
    send_file(f);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stalls_asked++;
        end
      endcase
      while (bytes_offered < (ph + 1) * TargetBytes / 3) begin
        make_file(f);
        send_file(f);
      end
      drain();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (dims.errors == 0) $display("image_header_dimension_sniffer_core_tb: clean");
    else $display("image_header_dimension_sniffer_core_tb: errors");
    $finish;
  end
endmodule
